/* rtl/core/dfwb_pkg.sv */
// ----------------------------------------------------------------------------
// dfwb_pkg
// Shared types and constants of the distance falloff weight blur block.
// ----------------------------------------------------------------------------
`default_nettype none
package dfwb_pkg;

  localparam int COORD_W = 24;
  localparam int DIST_W  = 24;
  localparam int BONE_W  = 10;
  localparam int WGT_W   = 16;
  localparam int OWGT_W  = 32;
  localparam int VCNT_W  = 13;
  localparam int IDX_W   = 12;
  localparam int RAD_W   = 50;
  localparam int NUM_W   = WGT_W + DIST_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 2'd2;

  typedef struct packed {
    logic [1:0]                opcode;
    logic [IDX_W-1:0]          vertex_index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [BONE_W-1:0]         bone_id;
    logic [WGT_W-1:0]          bone_weight;
  } in_item_t;

  typedef struct packed {
    logic [BONE_W-1:0] out_bone;
    logic [OWGT_W-1:0] out_weight;
    logic              last;
    logic              empty_res;
    logic              overflow;
  } out_item_t;

  typedef struct packed {
    logic clr_wr;
    logic take;
    logic load_wr;
    logic app_rd;
    logic app_wr;
    logic q_init;
    logic q_lat;
    logic v_rd;
    logic v_lat;
    logic mul;
    logic sq_init;
    logic sq_step;
    logic cls;
    logic e_rd;
    logic e_lat;
    logic div_mul;
    logic div_step;
    logic div_done;
    logic m_rd;
    logic m_cmp;
    logic k_next;
    logic v_next;
    logic emit;
    logic o_empty;
    logic o_rd;
    logic o_ld;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       clr_last;
    logic       in_range;
    logic       q_ok;
    logic       cnt_full;
    logic       mul_last;
    logic       sq_last;
    logic       skip;
    logic       full;
    logic       div_last;
    logic       m_end;
    logic       m_hit;
    logic       k_more;
    logic       v_more;
    logic       used_zero;
    logic       o_last;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/core/dfwb_ram.sv */
// ----------------------------------------------------------------------------
// dfwb_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module dfwb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

/* rtl/core/dfwb_ctrl.sv */
// ----------------------------------------------------------------------------
// dfwb_ctrl
// Sequencer: clear pass, load and append, query scan, merge and emit.
// ----------------------------------------------------------------------------
`default_nettype none
module dfwb_ctrl
  import dfwb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [4:0] ST_CLR     = 5'd0;
  localparam logic [4:0] ST_IDLE    = 5'd1;
  localparam logic [4:0] ST_LOAD    = 5'd2;
  localparam logic [4:0] ST_APP_RD  = 5'd3;
  localparam logic [4:0] ST_APP_WR  = 5'd4;
  localparam logic [4:0] ST_Q_INIT  = 5'd5;
  localparam logic [4:0] ST_Q_LAT   = 5'd6;
  localparam logic [4:0] ST_V_RD    = 5'd7;
  localparam logic [4:0] ST_V_LAT   = 5'd8;
  localparam logic [4:0] ST_MUL     = 5'd9;
  localparam logic [4:0] ST_SQ_INIT = 5'd10;
  localparam logic [4:0] ST_SQRT    = 5'd11;
  localparam logic [4:0] ST_CLASS   = 5'd12;
  localparam logic [4:0] ST_E_RD    = 5'd13;
  localparam logic [4:0] ST_E_LAT   = 5'd14;
  localparam logic [4:0] ST_DIV_MUL = 5'd15;
  localparam logic [4:0] ST_DIV     = 5'd16;
  localparam logic [4:0] ST_DIV_END = 5'd17;
  localparam logic [4:0] ST_M_RD    = 5'd18;
  localparam logic [4:0] ST_M_CMP   = 5'd19;
  localparam logic [4:0] ST_K_NEXT  = 5'd20;
  localparam logic [4:0] ST_V_NEXT  = 5'd21;
  localparam logic [4:0] ST_EMIT    = 5'd22;
  localparam logic [4:0] ST_O_EMPTY = 5'd23;
  localparam logic [4:0] ST_O_RD    = 5'd24;
  localparam logic [4:0] ST_O_LD    = 5'd25;

  logic [4:0] state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) begin
          unique case (sts.op)
            OP_LOAD:   state_nxt = ST_LOAD;
            OP_APPEND: state_nxt = ST_APP_RD;
            OP_QUERY:  state_nxt = ST_Q_INIT;
            OP_NOP:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.load_wr = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_APP_RD: begin
        cmd.app_rd = 1'b1;
        state_nxt  = sts.in_range ? ST_APP_WR : ST_IDLE;
      end
      ST_APP_WR: begin
        cmd.app_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_Q_INIT: begin
        cmd.q_init = 1'b1;
        state_nxt  = sts.q_ok ? ST_Q_LAT : ST_EMIT;
      end
      ST_Q_LAT: begin
        cmd.q_lat = 1'b1;
        state_nxt = ST_V_RD;
      end
      ST_V_RD: begin
        cmd.v_rd  = 1'b1;
        state_nxt = ST_V_LAT;
      end
      ST_V_LAT: begin
        cmd.v_lat = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        if (sts.mul_last) state_nxt = ST_SQ_INIT;
      end
      ST_SQ_INIT: begin
        cmd.sq_init = 1'b1;
        state_nxt   = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sq_step = 1'b1;
        if (sts.sq_last) state_nxt = ST_CLASS;
      end
      ST_CLASS: begin
        cmd.cls   = 1'b1;
        state_nxt = sts.skip ? ST_V_NEXT : ST_E_RD;
      end
      ST_E_RD: begin
        cmd.e_rd  = 1'b1;
        state_nxt = ST_E_LAT;
      end
      ST_E_LAT: begin
        cmd.e_lat = 1'b1;
        state_nxt = sts.full ? ST_M_RD : ST_DIV_MUL;
      end
      ST_DIV_MUL: begin
        cmd.div_mul = 1'b1;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_DIV_END;
      end
      ST_DIV_END: begin
        cmd.div_done = 1'b1;
        state_nxt    = ST_M_RD;
      end
      ST_M_RD: begin
        cmd.m_rd  = 1'b1;
        state_nxt = sts.m_end ? ST_K_NEXT : ST_M_CMP;
      end
      ST_M_CMP: begin
        cmd.m_cmp = 1'b1;
        state_nxt = sts.m_hit ? ST_K_NEXT : ST_M_RD;
      end
      ST_K_NEXT: begin
        cmd.k_next = 1'b1;
        state_nxt  = sts.k_more ? ST_E_RD : ST_V_NEXT;
      end
      ST_V_NEXT: begin
        cmd.v_next = 1'b1;
        state_nxt  = sts.v_more ? ST_V_RD : ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = sts.used_zero ? ST_O_EMPTY : ST_O_RD;
      end
      ST_O_EMPTY: begin
        cmd.o_empty = sts.out_free;
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_O_RD: begin
        cmd.o_rd  = 1'b1;
        state_nxt = ST_O_LD;
      end
      ST_O_LD: begin
        cmd.o_ld = sts.out_free;
        if (sts.out_free) state_nxt = sts.o_last ? ST_IDLE : ST_O_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/dfwb_dp.sv */
// ----------------------------------------------------------------------------
// dfwb_dp
// Datapath: stores, distance, square root, falloff divide, merge, output beat.
// ----------------------------------------------------------------------------
`default_nettype none
module dfwb_dp
  import dfwb_pkg::*;
#(
  parameter int MAX_VERTS          = 4096,
  parameter int MAX_BONES_PER_VERT = 8,
  parameter int MERGE_SLOTS        = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire in_item_t              in_data,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output out_item_t                  out_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  input  wire cmd_t                  cmd,
  output sts_t                       sts
);

  localparam int VIDX_W = $clog2(MAX_VERTS);
  localparam int SCAN_W = $clog2(MAX_VERTS + 1);
  localparam int CNT_W  = $clog2(MAX_BONES_PER_VERT + 1);
  localparam int EIDX_W = $clog2(MAX_VERTS * MAX_BONES_PER_VERT);
  localparam int SLOT_W = $clog2(MERGE_SLOTS);
  localparam int ENT_W  = BONE_W + WGT_W;
  localparam int SLOTD_W = BONE_W + OWGT_W;
  localparam int POS_W  = 3 * COORD_W;

  in_item_t                  item_r;
  logic [VCNT_W-1:0]         vc_r;
  logic [DIST_W-1:0]         min_r, max_r;
  logic [VIDX_W-1:0]         clr_r, v_r, j_unused;
  logic signed [COORD_W-1:0] qx_r, qy_r, qz_r;
  logic [CNT_W-1:0]          n_r, k_r;
  logic [COORD_W-1:0]        dx_r, dy_r, dz_r;
  logic [2*COORD_W-1:0]      prod_r;
  logic [RAD_W-1:0]          acc_r, rad_r, root_r;
  logic [RAD_W-2:0]          bit_r;
  logic [1:0]                ph_r;
  logic                      full_r;
  logic [BONE_W-1:0]         bone_r;
  logic [WGT_W-1:0]          w_r;
  logic [NUM_W-1:0]          num_r;
  logic [DIST_W-1:0]         rem_r;
  logic [5:0]                dcnt_r;
  logic [SLOT_W:0]           i_r, used_r, j_r;
  logic                      ovf_r;
  out_item_t                 out_r;
  logic                      out_valid_r;

  logic [SCAN_W-1:0]   scan;
  logic [VIDX_W-1:0]   idx;
  logic                pos_we, cnt_we, ent_we, slot_we;
  logic [VIDX_W-1:0]   pos_addr, cnt_addr;
  logic [EIDX_W-1:0]   ent_addr;
  logic [SLOT_W-1:0]   slot_addr;
  logic [POS_W-1:0]    pos_rdata;
  logic [CNT_W-1:0]    cnt_rdata, cnt_wdata;
  logic [ENT_W-1:0]    ent_rdata;
  logic [SLOTD_W-1:0]  slot_rdata, slot_wdata;
  logic [COORD_W:0]    ddx, ddy, ddz;
  logic [COORD_W-1:0]  msel;
  logic [RAD_W-1:0]    sq_sum;
  logic                le_min, le_max;
  logic [DIST_W-1:0]   span;
  logic [DIST_W:0]     rem_sh;
  logic                qbit;
  logic [OWGT_W:0]     wsum;
  logic [OWGT_W-1:0]   wsat;
  logic                slot_room;

  assign j_unused = '0;
  assign idx  = VIDX_W'(item_r.vertex_index);
  assign scan = (32'(vc_r) > MAX_VERTS) ? SCAN_W'(MAX_VERTS) : SCAN_W'(vc_r);
  assign span = max_r - min_r;

  // store ports
  assign pos_addr  = cmd.v_rd ? v_r : idx;
  assign pos_we    = cmd.load_wr && sts.in_range;
  assign cnt_addr  = cmd.clr_wr ? clr_r : (cmd.v_rd ? v_r : idx);
  assign cnt_we    = cmd.clr_wr || pos_we || (cmd.app_wr && !sts.cnt_full);
  assign cnt_wdata = cmd.app_wr ? cnt_rdata + CNT_W'(1) : '0;
  assign ent_addr  = cmd.app_wr
                   ? EIDX_W'(32'(idx) * MAX_BONES_PER_VERT + 32'(cnt_rdata))
                   : EIDX_W'(32'(v_r) * MAX_BONES_PER_VERT + 32'(k_r));
  assign ent_we    = cmd.app_wr && !sts.cnt_full;

  assign slot_room = 32'(used_r) < MERGE_SLOTS;
  assign wsum      = (OWGT_W + 1)'(slot_rdata[OWGT_W-1:0]) + (OWGT_W + 1)'(w_r);
  assign wsat      = wsum[OWGT_W] ? '1 : wsum[OWGT_W-1:0];
  always_comb begin
    if (cmd.m_rd && sts.m_end) begin
      slot_addr = used_r[SLOT_W-1:0];
    end else if (cmd.m_rd || cmd.m_cmp) begin
      slot_addr = i_r[SLOT_W-1:0];
    end else begin
      slot_addr = j_r[SLOT_W-1:0];
    end
  end
  assign slot_we    = (cmd.m_rd && sts.m_end && slot_room) || (cmd.m_cmp && sts.m_hit);
  assign slot_wdata = cmd.m_cmp ? {bone_r, wsat} : {bone_r, OWGT_W'(w_r)};

  dfwb_ram #(.WIDTH(POS_W), .DEPTH(MAX_VERTS)) u_pos_ram (
    .clk(clk), .we(pos_we), .addr(pos_addr),
    .wdata({item_r.pos_x, item_r.pos_y, item_r.pos_z}), .rdata(pos_rdata)
  );
  dfwb_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VERTS)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .addr(cnt_addr), .wdata(cnt_wdata), .rdata(cnt_rdata)
  );
  dfwb_ram #(.WIDTH(ENT_W), .DEPTH(MAX_VERTS * MAX_BONES_PER_VERT)) u_ent_ram (
    .clk(clk), .we(ent_we), .addr(ent_addr),
    .wdata({item_r.bone_id, item_r.bone_weight}), .rdata(ent_rdata)
  );
  dfwb_ram #(.WIDTH(SLOTD_W), .DEPTH(MERGE_SLOTS)) u_slot_ram (
    .clk(clk), .we(slot_we), .addr(slot_addr), .wdata(slot_wdata), .rdata(slot_rdata)
  );

  // distance arithmetic
  assign ddx = {pos_rdata[3*COORD_W-1], pos_rdata[3*COORD_W-1:2*COORD_W]} - {qx_r[COORD_W-1], qx_r};
  assign ddy = {pos_rdata[2*COORD_W-1], pos_rdata[2*COORD_W-1:COORD_W]} - {qy_r[COORD_W-1], qy_r};
  assign ddz = {pos_rdata[COORD_W-1], pos_rdata[COORD_W-1:0]} - {qz_r[COORD_W-1], qz_r};

  always_comb begin
    unique case (ph_r)
      2'd0:    msel = dx_r;
      2'd1:    msel = dy_r;
      2'd2:    msel = dz_r;
      default: msel = '0;
    endcase
  end

  assign sq_sum = root_r + RAD_W'(bit_r);
  assign le_min = root_r <= RAD_W'(min_r);
  assign le_max = root_r <= RAD_W'(max_r);
  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign qbit   = rem_sh >= {1'b0, span};

  // status
  assign sts.op        = in_data.opcode;
  assign sts.clr_last  = 32'(clr_r) == MAX_VERTS - 1;
  assign sts.in_range  = 32'(item_r.vertex_index) < MAX_VERTS;
  assign sts.q_ok      = 32'(item_r.vertex_index) < 32'(scan);
  assign sts.cnt_full  = 32'(cnt_rdata) >= MAX_BONES_PER_VERT;
  assign sts.mul_last  = ph_r == 2'd3;
  assign sts.sq_last   = bit_r[0];
  assign sts.skip      = (!le_min && !le_max) || (n_r == '0);
  assign sts.full      = full_r;
  assign sts.div_last  = dcnt_r == 6'(NUM_W - 1);
  assign sts.m_end     = i_r == used_r;
  assign sts.m_hit     = slot_rdata[SLOTD_W-1:OWGT_W] == bone_r;
  assign sts.k_more    = (32'(k_r) + 1 < 32'(n_r)) && (32'(k_r) + 1 < MAX_BONES_PER_VERT);
  assign sts.v_more    = (SCAN_W'(v_r) + SCAN_W'(1)) < scan;
  assign sts.used_zero = used_r == '0;
  assign sts.o_last    = j_r + 1'b1 == used_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r        <= '0;
      min_r       <= '0;
      max_r       <= '0;
      clr_r       <= '0;
      used_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_VERTEX_COUNT: vc_r  <= cfg_data[VCNT_W-1:0];
          CFG_MIN_DISTANCE: min_r <= cfg_data;
          CFG_MAX_DISTANCE: max_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clr_wr) clr_r <= clr_r + VIDX_W'(1) + j_unused;
      if (cmd.q_init) begin
        used_r <= '0;
        ovf_r  <= 1'b0;
      end
      if (cmd.m_rd && sts.m_end) begin
        if (slot_room) used_r <= used_r + 1'b1;
        else           ovf_r  <= 1'b1;
      end
      if (cmd.o_empty || cmd.o_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) item_r <= in_data;
    if (cmd.q_lat) begin
      qx_r <= pos_rdata[3*COORD_W-1:2*COORD_W];
      qy_r <= pos_rdata[2*COORD_W-1:COORD_W];
      qz_r <= pos_rdata[COORD_W-1:0];
      v_r  <= '0;
    end
    if (cmd.v_next) v_r <= v_r + VIDX_W'(1);
    if (cmd.v_lat) begin
      dx_r   <= ddx[COORD_W] ? COORD_W'(-ddx) : ddx[COORD_W-1:0];
      dy_r   <= ddy[COORD_W] ? COORD_W'(-ddy) : ddy[COORD_W-1:0];
      dz_r   <= ddz[COORD_W] ? COORD_W'(-ddz) : ddz[COORD_W-1:0];
      n_r    <= cnt_rdata;
      prod_r <= '0;
      acc_r  <= '0;
      ph_r   <= '0;
    end
    if (cmd.mul) begin
      prod_r <= msel * msel;
      acc_r  <= acc_r + RAD_W'(prod_r);
      ph_r   <= ph_r + 2'd1;
    end
    if (cmd.sq_init) begin
      rad_r  <= acc_r;
      root_r <= '0;
      bit_r  <= {1'b1, {(RAD_W-2){1'b0}}};
    end
    if (cmd.sq_step) begin
      if (rad_r >= sq_sum) begin
        rad_r  <= rad_r - sq_sum;
        root_r <= (root_r >> 1) + RAD_W'(bit_r);
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.cls) begin
      full_r <= le_min;
      k_r    <= '0;
    end
    if (cmd.k_next) k_r <= k_r + CNT_W'(1);
    if (cmd.e_lat) begin
      bone_r <= ent_rdata[ENT_W-1:WGT_W];
      w_r    <= ent_rdata[WGT_W-1:0];
      i_r    <= '0;
    end
    if (cmd.div_mul) begin
      num_r  <= w_r * (max_r - root_r[DIST_W-1:0]);
      rem_r  <= '0;
      dcnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= qbit ? DIST_W'(rem_sh - {1'b0, span}) : rem_sh[DIST_W-1:0];
      num_r  <= {num_r[NUM_W-2:0], qbit};
      dcnt_r <= dcnt_r + 6'd1;
    end
    if (cmd.div_done) w_r <= num_r[WGT_W-1:0];
    if (cmd.m_cmp && !sts.m_hit) i_r <= i_r + 1'b1;
    if (cmd.emit) j_r <= '0;
    if (cmd.o_ld) j_r <= j_r + 1'b1;
    if (cmd.o_empty) begin
      out_r.out_bone   <= '0;
      out_r.out_weight <= '0;
      out_r.last       <= 1'b1;
      out_r.empty_res  <= 1'b1;
      out_r.overflow   <= 1'b0;
    end
    if (cmd.o_ld) begin
      out_r.out_bone   <= slot_rdata[SLOTD_W-1:OWGT_W];
      out_r.out_weight <= slot_rdata[OWGT_W-1:0];
      out_r.last       <= sts.o_last;
      out_r.empty_res  <= 1'b0;
      out_r.overflow   <= ovf_r;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/distance_falloff_weight_blur_top.sv */
// ----------------------------------------------------------------------------
// distance_falloff_weight_blur_top
// Distance falloff weight blur: vertex store, distance scan and bone merge.
// ----------------------------------------------------------------------------
// After reset the bone count store is cleared, during which no input beat is
// taken. A query walks every vertex below vertex_count (capped at MAX_VERTS):
// the squared distance on one multiplier, the bit-pair square root with its
// setup, then per bone entry a read and advance, the falloff divide when the
// vertex lies in the falloff band, and the linear slot search over the merge
// slots, which claims a new slot or drops the bone. Results then leave one
// beat at a time, held while the receiver stalls.
// Input is held off from acceptance until the block is back in idle.
// ----------------------------------------------------------------------------
`default_nettype none
module distance_falloff_weight_blur_top
  import dfwb_pkg::*;
#(
  parameter int MAX_VERTS          = 4096,
  parameter int MAX_BONES_PER_VERT = 8,
  parameter int MERGE_SLOTS        = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  dfwb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  dfwb_dp #(
    .MAX_VERTS(MAX_VERTS),
    .MAX_BONES_PER_VERT(MAX_BONES_PER_VERT),
    .MERGE_SLOTS(MERGE_SLOTS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .sts(sts)
  );

endmodule
`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the distance falloff weight blur block. A short
// table of directed beats covers field extremes, every opcode, empty and
// out-of-range queries, full bone lists and zero weights. Random phases then
// run under several register settings and idle/stall mixes. Each accepted
// query is scored against a local model of the vertex store, distance scan
// and bone merge, or, for typed table rows, against the row's expected beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  import dfwb_pkg::*;

  localparam int NVERT = 4096;
  localparam int NBPV  = 8;
  localparam int NSLOT = 64;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  distance_falloff_weight_blur_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // vertex store and register mirror
  int          vx [NVERT];
  int          vy [NVERT];
  int          vz [NVERT];
  int unsigned bcnt [NVERT];
  logic [BONE_W-1:0] ebone [NVERT][NBPV];
  logic [WGT_W-1:0]  ewgt  [NVERT][NBPV];
  int unsigned vcount_r, mind_r, maxd_r;

  out_item_t   merged_q[$];
  int          errors;
  int          idle_pct;
  int          stall_pct;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t ex;
  } row_t;
  row_t dir_rows[$];

  initial begin
    clk = 1'b0;
  end
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned adiff(input int a, input int b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? -d : d;
  endfunction

  function automatic void blur_query(input int vi);
    logic [BONE_W-1:0] sb [NSLOT];
    longint unsigned   sw [NSLOT];
    int unsigned       used, scan;
    bit                ovf, hit;
    longint unsigned   dx, dy, dz, d, w;
    out_item_t         o;
    used = 0;
    ovf  = 0;
    scan = (vcount_r > NVERT) ? NVERT : vcount_r;
    if (vi < scan) begin
      for (int v = 0; v < scan; v++) begin
        dx = adiff(vx[v], vx[vi]);
        dy = adiff(vy[v], vy[vi]);
        dz = adiff(vz[v], vz[vi]);
        d  = isqrt(dx * dx + dy * dy + dz * dz);
        if (d > maxd_r && d > mind_r) continue;
        for (int k = 0; k < bcnt[v]; k++) begin
          w = 64'(ewgt[v][k]);
          if (d > mind_r) w = (w * (maxd_r - d)) / (maxd_r - mind_r);
          hit = 0;
          for (int s = 0; s < used; s++) begin
            if (!hit && sb[s] == ebone[v][k]) begin
              sw[s] = (sw[s] + w > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : sw[s] + w;
              hit = 1;
            end
          end
          if (!hit) begin
            if (used < NSLOT) begin
              sb[used] = ebone[v][k];
              sw[used] = w;
              used++;
            end else begin
              ovf = 1;
            end
          end
        end
      end
    end
    if (used == 0) begin
      o = '0;
      o.last = 1'b1;
      o.empty_res = 1'b1;
      merged_q.push_back(o);
    end else begin
      for (int s = 0; s < used; s++) begin
        o.out_bone   = sb[s];
        o.out_weight = sw[s][31:0];
        o.last       = (s + 1 == used);
        o.empty_res  = 1'b0;
        o.overflow   = ovf;
        merged_q.push_back(o);
      end
    end
  endfunction

  function automatic void store_update(input in_item_t it, input bit score);
    int vi;
    vi = int'(it.vertex_index);
    case (it.opcode)
      OP_LOAD: begin
        vx[vi] = int'(it.pos_x);
        vy[vi] = int'(it.pos_y);
        vz[vi] = int'(it.pos_z);
        bcnt[vi] = 0;
      end
      OP_APPEND: begin
        if (bcnt[vi] < NBPV) begin
          ebone[vi][bcnt[vi]] = it.bone_id;
          ewgt[vi][bcnt[vi]]  = it.bone_weight;
          bcnt[vi]++;
        end
      end
      OP_QUERY: begin
        if (score) blur_query(vi);
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t mk(input logic [1:0] op, input int vi, input int x,
                                  input int y, input int z, input int b, input int w);
    in_item_t it;
    it.opcode = op;
    it.vertex_index = IDX_W'(vi);
    it.pos_x = COORD_W'(x);
    it.pos_y = COORD_W'(y);
    it.pos_z = COORD_W'(z);
    it.bone_id = BONE_W'(b);
    it.bone_weight = WGT_W'(w);
    return it;
  endfunction

  function automatic out_item_t mko(input int b, input int w, input bit l, input bit e);
    out_item_t o;
    o.out_bone = BONE_W'(b);
    o.out_weight = OWGT_W'(w);
    o.last = l;
    o.empty_res = e;
    o.overflow = 1'b0;
    return o;
  endfunction

  function automatic void add_row(input in_item_t it, input bit typed, input out_item_t ex);
    row_t r;
    r.it = it;
    r.typed = typed;
    r.ex = ex;
    dir_rows.push_back(r);
  endfunction

  function automatic int rnd_coord();
    if ($urandom_range(9) == 0) return int'({{8{1'b0}}, $urandom} << 8) >>> 8;
    return int'($urandom_range(0, 'hC00)) - 'h600;
  endfunction

  task automatic send(input in_item_t it, input bit score);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    store_update(it, score);
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (merged_q.size() != 0) @(posedge clk);
    while (n < 400) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_VERTEX_COUNT: vcount_r = val & 'h1FFF;
      CFG_MIN_DISTANCE: mind_r = val & 'hFF_FFFF;
      default:          maxd_r = val & 'hFF_FFFF;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(input int unsigned n, input int unsigned lo, input int unsigned hi);
    write_reg(CFG_VERTEX_COUNT, n);
    write_reg(CFG_MIN_DISTANCE, lo);
    write_reg(CFG_MAX_DISTANCE, hi);
  endtask

  task automatic random_phase(input int n, input int nfill, input int nrand);
    int sel, vi, fill;
    for (int v = 0; v < n; v++)
      send(mk(OP_LOAD, v, rnd_coord(), rnd_coord(), rnd_coord(), $urandom, $urandom), 1);
    for (int v = 0; v < n; v++) begin
      fill = (nfill < 0) ? $urandom_range(0, NBPV) : nfill;
      for (int k = 0; k < fill; k++)
        send(mk(OP_APPEND, v, $urandom, $urandom, $urandom,
                ($urandom_range(1) != 0) ? $urandom_range(0, 7) : $urandom, $urandom), 1);
    end
    for (int i = 0; i < nrand; i++) begin
      sel = $urandom_range(99);
      vi  = ($urandom_range(4) == 0) ? $urandom_range(0, NVERT - 1) : $urandom_range(0, n - 1);
      if (sel < 40)
        send(mk(OP_APPEND, vi, $urandom, $urandom, $urandom,
                ($urandom_range(1) != 0) ? $urandom_range(0, 7) : $urandom, $urandom), 1);
      else if (sel < 55)
        send(mk(OP_LOAD, vi, rnd_coord(), rnd_coord(), rnd_coord(), $urandom, $urandom), 1);
      else if (sel < 90)
        send(mk(OP_QUERY, vi, $urandom, $urandom, $urandom, $urandom, $urandom), 1);
      else
        send(mk(OP_NOP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom), 1);
    end
    send(mk(OP_QUERY, $urandom_range(0, n - 1), 0, 0, 0, 0, 0), 1);
    drain();
  endtask

  // score result beats and randomize receiver stall
  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (merged_q.size() == 0) begin
          $error("unexpected result beat bone %0d weight %0d", out_data.out_bone,
                 out_data.out_weight);
          errors++;
        end else begin
          e = merged_q.pop_front();
          if (out_data.out_bone !== e.out_bone) begin
            $error("out_bone exp %0d got %0d", e.out_bone, out_data.out_bone);
            errors++;
          end
          if (out_data.out_weight !== e.out_weight) begin
            $error("out_weight exp %0d got %0d", e.out_weight, out_data.out_weight);
            errors++;
          end
          if (out_data.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_data.last);
            errors++;
          end
          if (out_data.empty_res !== e.empty_res) begin
            $error("empty_res exp %0d got %0d", e.empty_res, out_data.empty_res);
            errors++;
          end
          if (out_data.overflow !== e.overflow) begin
            $error("overflow exp %0d got %0d", e.overflow, out_data.overflow);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    out_item_t none;
    none = '0;
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_VERTEX_COUNT;
    cfg_data = '0;
    vcount_r = 0;
    mind_r = 0;
    maxd_r = 0;
    foreach (bcnt[i]) bcnt[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    add_row(mk(OP_QUERY, 'h800, 0, 0, 0, 0, 0), 1, mko(0, 0, 1, 1));
    add_row(mk(OP_LOAD, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk(OP_LOAD, 1, 'h100, 0, 0, 0, 0), 0, none);
    add_row(mk(OP_LOAD, 2, 'h200, 0, 0, 0, 0), 0, none);
    add_row(mk(OP_LOAD, 3, 'h7F_FFFF, 'h7F_FFFF, 'h7F_FFFF, 'h3FF, 'hFFFF), 0, none);
    add_row(mk(OP_APPEND, 0, 0, 0, 0, 0, 32768), 0, none);
    add_row(mk(OP_APPEND, 1, 0, 0, 0, 0, 32768), 0, none);
    add_row(mk(OP_APPEND, 2, 0, 0, 0, 'h3FF, 'hFFFF), 0, none);
    add_row(mk(OP_APPEND, 3, 0, 0, 0, 5, 100), 0, none);
    add_row(mk(OP_QUERY, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk(OP_QUERY, 3, 0, 0, 0, 0, 0), 1, mko(5, 100, 1, 0));
    add_row(mk(OP_LOAD, 3, -'h80_0000, -'h80_0000, -'h80_0000, 0, 0), 0, none);
    add_row(mk(OP_QUERY, 3, 0, 0, 0, 0, 0), 1, mko(0, 0, 1, 1));
    add_row(mk(OP_NOP, 'hFFF, -1, -1, -1, 'h3FF, 'hFFFF), 0, none);
    add_row(mk(OP_LOAD, 'hFFF, 1, -1, 'h55, 0, 0), 0, none);
    for (int k = 0; k < NBPV; k++)
      add_row(mk(OP_APPEND, 0, 0, 0, 0, 'h200 + k, (k == 2) ? 0 : 'h1000 * k + 7), 0, none);
    add_row(mk(OP_QUERY, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk(OP_QUERY, 'hFFF, 0, 0, 0, 0, 0), 1, mko(0, 0, 1, 1));

    set_regs(4, 'h100, 'h400);
    foreach (dir_rows[i]) begin
      send(dir_rows[i].it, !dir_rows[i].typed);
      if (dir_rows[i].typed && dir_rows[i].it.opcode == OP_QUERY)
        merged_q.push_back(dir_rows[i].ex);
    end
    drain();

    idle_pct = 0;  stall_pct = 0;
    set_regs(3, 0, 0);
    random_phase(3, -1, 4);
    idle_pct = 72; stall_pct = 0;
    set_regs(2, 'h200, 'hFF_FFFF);
    random_phase(2, NBPV, 3);
    idle_pct = 0;  stall_pct = 72;
    set_regs(3, 'hFF_FFFF, 'hFF_FFFF);
    random_phase(3, -1, 4);
    idle_pct = 7;  stall_pct = 7;
    set_regs(3, 'h80, 'h900);
    random_phase(3, -1, 4);

    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
